FILE: hw/rtl/rspd_pkg.sv
// shared types, constants and a helper function for the packet deframer
`default_nettype none

package rspd_pkg;

    localparam int MaxPacket = 4096;
    localparam int LenW = 12;
    localparam int LenLimitInt = (MaxPacket - 1 > 4095) ? 4095 : MaxPacket - 1;
    localparam logic [LenW-1:0] LenLimit = LenLimitInt[LenW-1:0];

    localparam logic [7:0] ChIntr = 8'h03;
    localparam logic [7:0] ChStart = 8'h24;
    localparam logic [7:0] ChHash = 8'h23;

    localparam int AddrW = 3;
    localparam logic RegNoAck = 1'b0;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_INTR = 2'd2,
        KIND_OVF  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REPLY_NONE = 2'd0,
        REPLY_ACK  = 2'd1,
        REPLY_NAK  = 2'd2
    } reply_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       payload_byte;
        logic [LenW-1:0]  payload_length;
        logic             checksum_match;
        logic             deliver;
        reply_t           reply;
    } result_t;

    typedef struct packed {
        logic ok;
        logic [3:0] value;
    } hex_t;

    // ascii hex digit decode, invalid characters give value 0
    function automatic hex_t hex_decode(input logic [7:0] ch);
        hex_t h;
        h.ok = 1'b1;
        h.value = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.value = 4'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            h.value = 4'(ch - 8'h57);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            h.value = 4'(ch - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rspd_if.sv
// valid/ready channel interfaces for received bytes and deframer results
`default_nettype none

interface rspd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface rspd_result_if;
    logic                       valid;
    logic                       ready;
    rspd_pkg::kind_t            kind;
    logic [7:0]                 payload_byte;
    logic [rspd_pkg::LenW-1:0]  payload_length;
    logic                       checksum_match;
    logic                       deliver;
    rspd_pkg::reply_t           reply;

    modport source (output valid, output kind, output payload_byte, output payload_length,
                    output checksum_match, output deliver, output reply, input ready);
    modport sink (input valid, input kind, input payload_byte, input payload_length,
                  input checksum_match, input deliver, input reply, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rspd_cfg.sv
// apb configuration register block
`default_nettype none

module rspd_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rspd_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic                            ack_disable
);

    logic no_ack_reg;
    logic no_ack_next;
    logic reg_idx;

    assign reg_idx = paddr[2];
    assign pready = 1'b1;
    assign ack_disable = no_ack_reg;

    always_comb
    begin
        no_ack_next = no_ack_reg;
        if (psel && penable && pwrite && reg_idx == rspd_pkg::RegNoAck)
        begin
            no_ack_next = pwdata[0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (reg_idx == rspd_pkg::RegNoAck)
        begin
            prdata = {31'd0, no_ack_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_ack_reg <= 1'b0;
        end
        else
        begin
            no_ack_reg <= no_ack_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rspd_parser.sv
// input byte register and framing state update
`default_nettype none

module rspd_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_byte,
    input  wire logic          ack_disable,
    input  wire logic          out_free,
    output logic               res_load,
    output rspd_pkg::result_t  res_data
);

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [7:0]                 s1_byte_reg;
    rspd_pkg::phase_t           phase_reg;
    rspd_pkg::phase_t           phase_next;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic [rspd_pkg::LenW-1:0]  count_reg;
    logic [rspd_pkg::LenW-1:0]  count_next;
    logic [3:0]                 high_reg;
    logic [3:0]                 high_next;
    logic                       bad_reg;
    logic                       bad_next;
    logic                       advance;
    logic                       has_result;
    logic                       match;
    rspd_pkg::hex_t             hex;

    // the held byte is processed once the result register can take its outcome
    assign advance = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || advance;
    assign s1_valid_next = in_valid ? 1'b1 : (s1_valid_reg && !advance);
    assign hex = rspd_pkg::hex_decode(s1_byte_reg);
    assign match = hex.ok && !bad_reg && ({high_reg, hex.value} == sum_reg);
    assign res_load = advance && has_result;

    always_comb
    begin
        phase_next = phase_reg;
        sum_next = sum_reg;
        count_next = count_reg;
        high_next = high_reg;
        bad_next = bad_reg;
        has_result = 1'b0;
        res_data = '0;
        res_data.kind = rspd_pkg::KIND_BYTE;
        res_data.reply = rspd_pkg::REPLY_NONE;
        if (s1_byte_reg == rspd_pkg::ChIntr)
        begin
            has_result = 1'b1;
            res_data.kind = rspd_pkg::KIND_INTR;
        end
        else
        begin
            unique case (phase_reg)
                rspd_pkg::PH_HUNT:
                begin
                    if (s1_byte_reg == rspd_pkg::ChStart)
                    begin
                        phase_next = rspd_pkg::PH_DATA;
                        sum_next = 8'd0;
                        count_next = '0;
                        high_next = 4'd0;
                        bad_next = 1'b0;
                    end
                end
                rspd_pkg::PH_DATA:
                begin
                    if (s1_byte_reg == rspd_pkg::ChHash)
                    begin
                        phase_next = rspd_pkg::PH_HIGH;
                    end
                    else if (count_reg >= rspd_pkg::LenLimit)
                    begin
                        has_result = 1'b1;
                        res_data.kind = rspd_pkg::KIND_OVF;
                        res_data.payload_length = count_reg;
                        phase_next = rspd_pkg::PH_HUNT;
                    end
                    else
                    begin
                        has_result = 1'b1;
                        res_data.payload_byte = s1_byte_reg;
                        sum_next = sum_reg + s1_byte_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                rspd_pkg::PH_HIGH:
                begin
                    high_next = hex.value;
                    bad_next = !hex.ok;
                    phase_next = rspd_pkg::PH_LOW;
                end
                rspd_pkg::PH_LOW:
                begin
                    has_result = 1'b1;
                    res_data.kind = rspd_pkg::KIND_END;
                    res_data.payload_length = count_reg;
                    res_data.checksum_match = match;
                    res_data.deliver = match || ack_disable;
                    if (ack_disable)
                    begin
                        res_data.reply = rspd_pkg::REPLY_NONE;
                    end
                    else if (match)
                    begin
                        res_data.reply = rspd_pkg::REPLY_ACK;
                    end
                    else
                    begin
                        res_data.reply = rspd_pkg::REPLY_NAK;
                    end
                    phase_next = rspd_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = rspd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg <= rspd_pkg::PH_HUNT;
            sum_reg <= 8'd0;
            count_reg <= '0;
            high_reg <= 4'd0;
            bad_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                sum_reg <= sum_next;
                count_reg <= count_next;
                high_reg <= high_next;
                bad_reg <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rspd_out_reg.sv
// result register toward the downstream sink
`default_nettype none

module rspd_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire rspd_pkg::result_t  load_data,
    output logic                    free,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rspd_pkg::result_t       out_data
);

    logic               valid_reg;
    logic               valid_next;
    rspd_pkg::result_t  data_reg;

    assign free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rsp_packet_deframer.sv
// Remote debug packet deframer. Takes one received byte per transaction on rx and
// produces at most one result per byte on evt: payload bytes, a packet end with length,
// checksum verdict, delivery flag and ack reply, interrupt requests for 0x03, and
// overflow errors for payloads beyond the length limit. A new byte is accepted every
// cycle while evt is ready: each byte is held in the input register, and its result is
// loaded into the result register once that register is free. The no-ack mode bit is
// written through the apb port at an address with paddr bit 2 clear; the user must
// write it only while the block is idle, which the block itself does not enforce.
`default_nettype none

module rsp_packet_deframer (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    rspd_byte_if.sink                       rx,
    rspd_result_if.source                   evt,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rspd_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic               ack_disable;
    logic               out_free;
    logic               res_load;
    rspd_pkg::result_t  res_data;
    rspd_pkg::result_t  out_data;

    rspd_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .ack_disable (ack_disable)
    );

    rspd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rx.valid),
        .in_ready    (rx.ready),
        .in_byte     (rx.rx_byte),
        .ack_disable (ack_disable),
        .out_free    (out_free),
        .res_load    (res_load),
        .res_data    (res_data)
    );

    rspd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .load_data (res_data),
        .free      (out_free),
        .out_valid (evt.valid),
        .out_ready (evt.ready),
        .out_data  (out_data)
    );

    assign evt.kind = out_data.kind;
    assign evt.payload_byte = out_data.payload_byte;
    assign evt.payload_length = out_data.payload_length;
    assign evt.checksum_match = out_data.checksum_match;
    assign evt.deliver = out_data.deliver;
    assign evt.reply = out_data.reply;

endmodule

`default_nettype wire
